/* rtl/assert_macros.svh */
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define BWF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, checked out of reset
`define BWF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* rtl/bwf_pkg.sv */
package bwf_pkg;

    // field and datapath widths
    localparam int SMP_W     = 16;
    localparam int GAIN_W    = 31;
    localparam int COEF_W    = 32;
    localparam int SUM_W     = 21;               // binomial-weighted input sum
    localparam int PROD_W    = COEF_W + SMP_W;   // one feedback product
    localparam int F_W       = PROD_W + 2;       // feedback sum over up to four taps
    localparam int ACC_W     = 53;               // gain product and accumulator
    localparam int FRAC_SH   = 27;               // fraction bits dropped at the output
    localparam int MAX_ORDER = 4;
    localparam int SMP_MAX   = 32767;
    localparam int SMP_MIN   = -32768;

    // configuration port
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGHPASS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_COEF1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_COEF2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_COEF3 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_COEF4 = 3'd5;

    typedef logic signed [SMP_W-1:0]  t_sample;
    typedef logic signed [COEF_W-1:0] t_coef;

    // per-cycle control handed to every tap
    typedef struct packed {
        logic x_shift;
        logic y_shift;
        logic highpass;
    } t_tap_ctrl;

    // binomial weight C(order, i), zero outside the triangle
    function automatic int bwf_binom(input int order, input int i);
        int w;
        w = 0;
        case (order)
            1: begin
                if (i == 0 || i == 1) w = 1;
            end
            2: begin
                if (i == 0 || i == 2) w = 1;
                else if (i == 1) w = 2;
            end
            3: begin
                if (i == 0 || i == 3) w = 1;
                else if (i == 1 || i == 2) w = 3;
            end
            4: begin
                if (i == 0 || i == 4) w = 1;
                else if (i == 1 || i == 3) w = 4;
                else if (i == 2) w = 6;
            end
            default: w = 0;
        endcase
        return w;
    endfunction

endpackage

/* rtl/butterworth_iir_filter.sv */
// an input transfer reaches o_valid through the r_s, r_ff and r_out registers
// throughput: one sample per cycle while o_stall is low; the recursion closes through
//   the feedback multipliers and adder chain of the tap cells
// o_stall rises only while a finished result waits and i_stall is high
// synchronous active-low reset clears configuration registers, histories and pipeline valids
module butterworth_iir_filter
    import bwf_pkg::*;
#(
    parameter int ORDER = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic signed [SMP_W-1:0] i_sample_in,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic signed [SMP_W-1:0] o_sample_out,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [COEF_W-1:0]      i_cfg_data
);

`include "assert_macros.svh"

    // order clamped to the supported range
    localparam int ORD = (ORDER > MAX_ORDER) ? MAX_ORDER : ((ORDER < 1) ? 1 : ORDER);
    localparam int Y_W = ACC_W - FRAC_SH;
    localparam logic signed [Y_W-1:0]   Y_MAX    = Y_W'(SMP_MAX);
    localparam logic signed [Y_W-1:0]   Y_MIN    = Y_W'(SMP_MIN);
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'd1 << (FRAC_SH - 1));

    // configuration registers
    logic [GAIN_W-1:0] r_gain;
    logic              r_highpass;
    t_coef             r_fb [MAX_ORDER];

    // pipeline registers
    logic                    r_s_valid;
    logic signed [SUM_W-1:0] r_s;
    logic                    r_ff_valid;
    logic signed [ACC_W-1:0] r_ff;
    logic                    r_out_valid;
    t_sample                 r_out;

    logic                    w_adv;
    logic                    w_in_acc;
    t_tap_ctrl               w_ctrl;
    t_sample                 w_x [ORD+1];
    t_sample                 w_y [ORD+1];
    logic signed [SUM_W-1:0] w_s [ORD+1];
    logic signed [F_W-1:0]   w_f [ORD+1];
    logic signed [ACC_W-1:0] n_ff;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] acc_rnd;
    logic signed [Y_W-1:0]   y_full;
    t_sample                 n_out;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain     <= '0;
            r_highpass <= 1'b0;
            for (int k = 0; k < MAX_ORDER; k++) begin
                r_fb[k] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GAIN:     r_gain     <= i_cfg_data[GAIN_W-1:0];
                CFG_HIGHPASS: r_highpass <= i_cfg_data[0];
                CFG_FB_COEF1: r_fb[0]    <= i_cfg_data;
                CFG_FB_COEF2: r_fb[1]    <= i_cfg_data;
                CFG_FB_COEF3: r_fb[2]    <= i_cfg_data;
                CFG_FB_COEF4: r_fb[3]    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // whole pipeline moves unless a result is held by the consumer
    assign w_adv    = !r_out_valid || !i_stall;
    assign w_in_acc = i_valid && w_adv;
    assign o_stall  = !w_adv;

    assign w_ctrl.x_shift  = w_in_acc;
    assign w_ctrl.y_shift  = w_adv && r_ff_valid;
    assign w_ctrl.highpass = r_highpass;

    // chain heads: newest sample enters, newest output feeds back
    assign w_x[0] = i_sample_in;
    assign w_y[0] = n_out;
    assign w_s[0] = SUM_W'(i_sample_in);
    assign w_f[0] = '0;

    // tap cells, one per delay
    for (genvar g = 0; g < ORD; g++) begin : g_tap
        bwf_tap #(
            .ORDER (ORD),
            .IDX   (g + 1)
        ) u_tap (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (w_ctrl),
            .i_fb_coef (r_fb[g]),
            .i_x       (w_x[g]),
            .i_y       (w_y[g]),
            .i_s_in    (w_s[g]),
            .i_f_in    (w_f[g]),
            .o_x       (w_x[g+1]),
            .o_y       (w_y[g+1]),
            .o_s_out   (w_s[g+1]),
            .o_f_out   (w_f[g+1])
        );
    end

    // gain applied to the registered weighted sum
    assign n_ff = $signed({1'b0, r_gain}) * r_s;

    // feedback subtract, round half up, saturate
    always_comb begin
        acc     = r_ff - ACC_W'(w_f[ORD]);
        acc_rnd = acc + RND_HALF;
        y_full  = acc_rnd[ACC_W-1:FRAC_SH];
        if (y_full > Y_MAX) begin
            n_out = t_sample'(SMP_MAX);
        end else if (y_full < Y_MIN) begin
            n_out = t_sample'(SMP_MIN);
        end else begin
            n_out = y_full[SMP_W-1:0];
        end
    end

    // pipeline stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid   <= 1'b0;
            r_ff_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s_valid   <= i_valid;
            r_ff_valid  <= r_s_valid;
            r_out_valid <= r_ff_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s   <= w_s[ORD];
            r_ff  <= n_ff;
            r_out <= n_out;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_sample_out = r_out;

    // newest input history entry is the sample just transferred
    `BWF_ASSERT_NXT(a_x_hist, i_clk, i_rst_n, w_in_acc, w_x[1] == $past(i_sample_in))
    // newest output history entry matches the result just produced
    `BWF_ASSERT_NXT(a_y_hist, i_clk, i_rst_n, w_ctrl.y_shift, w_y[1] == o_sample_out)
    // a held result freezes the inner stages
    `BWF_ASSERT_NXT(a_hold, i_clk, i_rst_n, r_out_valid && i_stall,
        $stable(r_s_valid) && $stable(r_ff_valid) && $stable(r_ff))

endmodule

/* rtl/bwf_tap.sv */
module bwf_tap
    import bwf_pkg::*;
#(
    parameter int ORDER = 4,
    parameter int IDX   = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_tap_ctrl               i_ctrl,
    input  t_coef                   i_fb_coef,
    input  t_sample                 i_x,
    input  t_sample                 i_y,
    input  logic signed [SUM_W-1:0] i_s_in,
    input  logic signed [F_W-1:0]   i_f_in,
    output t_sample                 o_x,
    output t_sample                 o_y,
    output logic signed [SUM_W-1:0] o_s_out,
    output logic signed [F_W-1:0]   o_f_out
);

    localparam logic signed [SUM_W-1:0] WGT = SUM_W'(bwf_binom(ORDER, IDX));
    localparam bit ODD = (IDX % 2) == 1;

    t_sample                 r_x;
    t_sample                 r_y;
    logic signed [SUM_W-1:0] x_ext;
    logic signed [SUM_W-1:0] w_term;
    logic signed [PROD_W-1:0] fb_prod;

    // history entries, shifted in from the neighbor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_y <= '0;
        end else begin
            if (i_ctrl.x_shift) begin
                r_x <= i_x;
            end
            if (i_ctrl.y_shift) begin
                r_y <= i_y;
            end
        end
    end

    // weighted input term, sign flipped on odd taps in high-pass mode
    always_comb begin
        x_ext  = SUM_W'(r_x);
        w_term = x_ext * WGT;
        if (ODD && i_ctrl.highpass) begin
            w_term = -w_term;
        end
    end

    // feedback product for this delay
    assign fb_prod = i_fb_coef * r_y;

    assign o_s_out = i_s_in + w_term;
    assign o_f_out = i_f_in + F_W'(fb_prod);
    assign o_x     = r_x;
    assign o_y     = r_y;

endmodule

/* tb/butterworth_iir_filter_tb.sv */
`timescale 1ns / 100ps

module butterworth_iir_filter_tb;
    import bwf_pkg::*;

    localparam int FILT_ORDER = 4;
    localparam int PIPE_LAT   = 3;
    localparam int STUCK_MAX  = 2000;
    localparam int NUM_DIR    = 32;
    localparam int NUM_SEG    = 8;
    localparam int SEG_ITEMS  = 118;
    localparam int MAX_SHOWN  = 50;

    // register indexes past the end of the map, writes there are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE7 = 3'd7;

    // idling per phase: none, sender only, receiver only, both
    localparam int SRC_IDLE_PCT [4]  = '{0, 52, 0, 33};
    localparam int SNK_STALL_PCT [4] = '{0, 0, 52, 33};

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_SAMPLE,
        ROW_KNOWN
    } t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [COEF_W-1:0]     data;
        t_sample               smp;
        t_sample               known;
    } t_dir_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    t_sample              i_sample_in = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    t_sample              o_sample_out;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [COEF_W-1:0]    i_cfg_data = '0;

    // side info traveling with the sample being offered
    bit      known_flag = 1'b0;
    t_sample known_val = '0;

    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int mismatch_cnt = 0;
    int stuck_cycles = 0;

    // filter state as seen by the predictor
    logic [GAIN_W-1:0] flt_gain = '0;
    logic              flt_highpass = 1'b0;
    t_coef             flt_fb [MAX_ORDER] = '{default: '0};
    t_sample           past_in [MAX_ORDER] = '{default: '0};
    t_sample           past_out [MAX_ORDER] = '{default: '0};
    t_sample           pred_y;
    t_sample           exp_y;

    t_sample sample_out_q [$];

    // directed rows: known results only where they are obvious
    t_dir_row dir_rows [NUM_DIR] = '{
        // zero gain out of reset, every result is zero
        '{ROW_KNOWN,  CFG_GAIN,     32'h0,         16'sh7FFF,   16'sh0000},
        '{ROW_KNOWN,  CFG_GAIN,     32'h0,         16'sh8000,   16'sh0000},
        '{ROW_KNOWN,  CFG_GAIN,     32'h0,         16'sh0000,   16'sh0000},
        '{ROW_KNOWN,  CFG_GAIN,     32'h0,         16'sh0000,   16'sh0000},
        '{ROW_KNOWN,  CFG_GAIN,     32'h0,         16'sh0000,   16'sh0000},
        '{ROW_KNOWN,  CFG_GAIN,     32'h0,         16'sh0000,   16'sh0000},
        // half gain on empty history: exact half lsb rounds up
        '{ROW_WRITE,  CFG_GAIN,     32'h0400_0000, 16'sh0000,   16'sh0000},
        '{ROW_KNOWN,  CFG_GAIN,     32'h0,         16'shFFFF,   16'sh0000},
        '{ROW_SAMPLE, CFG_GAIN,     32'h0,         16'sh0000,   16'sh0000},
        '{ROW_SAMPLE, CFG_GAIN,     32'h0,         16'sh0000,   16'sh0000},
        '{ROW_SAMPLE, CFG_GAIN,     32'h0,         16'sh0000,   16'sh0000},
        '{ROW_SAMPLE, CFG_GAIN,     32'h0,         16'sh0000,   16'sh0000},
        '{ROW_KNOWN,  CFG_GAIN,     32'h0,         16'sh0001,   16'sh0001},
        // top data bit dropped, max gain saturates high
        '{ROW_WRITE,  CFG_GAIN,     32'hFFFF_FFFF, 16'sh0000,   16'sh0000},
        '{ROW_KNOWN,  CFG_GAIN,     32'h0,         16'sh7FFF,   16'sh7FFF},
        '{ROW_SAMPLE, CFG_GAIN,     32'h0,         16'sh8000,   16'sh0000},
        '{ROW_SAMPLE, CFG_GAIN,     32'h0,         16'sh0000,   16'sh0000},
        // high-pass weights, only bit 0 of the data counts
        '{ROW_WRITE,  CFG_HIGHPASS, 32'hFFFF_FFFF, 16'sh0000,   16'sh0000},
        '{ROW_SAMPLE, CFG_GAIN,     32'h0,         16'sh8000,   16'sh0000},
        '{ROW_SAMPLE, CFG_GAIN,     32'h0,         16'sh7FFF,   16'sh0000},
        // unity gain, extreme feedback, writes past the register map
        '{ROW_WRITE,  CFG_GAIN,     32'h0800_0000, 16'sh0000,   16'sh0000},
        '{ROW_WRITE,  CFG_FB_COEF1, 32'h8000_0000, 16'sh0000,   16'sh0000},
        '{ROW_WRITE,  CFG_FB_COEF2, 32'h7FFF_FFFF, 16'sh0000,   16'sh0000},
        '{ROW_WRITE,  CFG_FB_COEF3, 32'h1234_5678, 16'sh0000,   16'sh0000},
        '{ROW_WRITE,  CFG_FB_COEF4, 32'hF000_0000, 16'sh0000,   16'sh0000},
        '{ROW_WRITE,  CFG_SPARE6,   32'hFFFF_FFFF, 16'sh0000,   16'sh0000},
        '{ROW_WRITE,  CFG_SPARE7,   32'h5A5A_A5A5, 16'sh0000,   16'sh0000},
        '{ROW_SAMPLE, CFG_GAIN,     32'h0,         16'sd1000,   16'sh0000},
        '{ROW_SAMPLE, CFG_GAIN,     32'h0,         16'shFC18,   16'sh0000},
        '{ROW_SAMPLE, CFG_GAIN,     32'h0,         16'sh0000,   16'sh0000},
        '{ROW_SAMPLE, CFG_GAIN,     32'h0,         16'sd12345,  16'sh0000},
        '{ROW_SAMPLE, CFG_GAIN,     32'h0,         16'sh8000,   16'sh0000}
    };

    butterworth_iir_filter #(
        .ORDER(FILT_ORDER)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_sample_in (i_sample_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_sample_out(o_sample_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // one step of the direct-form-I recursion, updates both histories
    function automatic t_sample iir_next_sample(input t_sample x);
        longint wt;
        longint taps;
        longint acc;
        longint rnd;
        t_sample tap;
        t_sample y;
        taps = 0;
        wt = 1;
        for (int i = 0; i <= FILT_ORDER; i++) begin
            tap = (i == 0) ? x : past_in[i-1];
            if (flt_highpass && i[0]) begin
                taps -= wt * longint'(tap);
            end else begin
                taps += wt * longint'(tap);
            end
            wt = wt * (FILT_ORDER - i) / (i + 1);
        end
        acc = longint'(flt_gain) * taps;
        for (int k = 0; k < FILT_ORDER; k++) begin
            acc -= longint'(flt_fb[k]) * longint'(past_out[k]);
        end
        // round half up, then clamp to the sample range
        rnd = (acc + (longint'(1) << (FRAC_SH - 1))) >>> FRAC_SH;
        if (rnd > SMP_MAX) begin
            y = t_sample'(SMP_MAX);
        end else if (rnd < SMP_MIN) begin
            y = t_sample'(SMP_MIN);
        end else begin
            y = t_sample'(rnd);
        end
        for (int k = MAX_ORDER - 1; k > 0; k--) begin
            past_in[k] = past_in[k-1];
            past_out[k] = past_out[k-1];
        end
        past_in[0] = x;
        past_out[0] = y;
        return y;
    endfunction

    task automatic report_mismatch(input string what, input t_sample got, input t_sample want);
        if (mismatch_cnt < MAX_SHOWN) begin
            $display("mismatch at %0t: %s: got %0d, want %0d", $time, what, got, want);
        end
        mismatch_cnt++;
    endtask

    // offer one sample after a random gap, return at the edge that takes it
    task automatic drive_sample(input t_sample smp, input bit known, input t_sample want);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample_in <= smp;
        known_flag <= known;
        known_val <= want;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // hold the sender until every pending result is out
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sample_out_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 2) @(posedge i_clk);
    endtask

    // one register write, the caller lowers the enable after a batch
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // receiver stall
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < snk_stall_pct);
    end

    // register writes and accepted samples feed the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GAIN:     flt_gain = i_cfg_data[GAIN_W-1:0];
                CFG_HIGHPASS: flt_highpass = i_cfg_data[0];
                CFG_FB_COEF1: flt_fb[0] = i_cfg_data;
                CFG_FB_COEF2: flt_fb[1] = i_cfg_data;
                CFG_FB_COEF3: flt_fb[2] = i_cfg_data;
                CFG_FB_COEF4: flt_fb[3] = i_cfg_data;
                default: ;
            endcase
        end
        if (i_rst_n && i_valid && !o_stall) begin
            pred_y = iir_next_sample(i_sample_in);
            sample_out_q.push_back(known_flag ? known_val : pred_y);
        end
    end

    // result check against the oldest pending sample
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (sample_out_q.size() == 0) begin
                report_mismatch("result with nothing pending", o_sample_out, '0);
            end else begin
                exp_y = sample_out_q.pop_front();
                if (o_sample_out !== exp_y) begin
                    report_mismatch("sample_out", o_sample_out, exp_y);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n && ((i_valid && !o_stall) || (o_valid && !i_stall))) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STUCK_MAX) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        bit writing;
        int mode;
        logic [COEF_W-1:0] gain_v;
        logic [COEF_W-1:0] hp_v;
        logic [COEF_W-1:0] fb_v [MAX_ORDER];
        t_sample smp;
        t_sample prev_smp;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows, writes only after the pipeline drains
        writing = 1'b0;
        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_WRITE) begin
                if (!writing) begin
                    wait_idle();
                    writing = 1'b1;
                end
                cfg_write(dir_rows[r].idx, dir_rows[r].data);
            end else begin
                if (writing) begin
                    i_cfg_we <= 1'b0;
                    writing = 1'b0;
                end
                drive_sample(dir_rows[r].smp, dir_rows[r].kind == ROW_KNOWN,
                             dir_rows[r].known);
            end
        end

        // random segments, a fresh setting each, two per idling phase
        prev_smp = '0;
        for (int seg = 0; seg < NUM_SEG; seg++) begin
            src_idle_pct = SRC_IDLE_PCT[seg / 2];
            snk_stall_pct = SNK_STALL_PCT[seg / 2];
            wait_idle();

            mode = seg % 4;
            hp_v = $urandom;
            case (mode)
                // low gain, small stable feedback
                0: begin
                    gain_v = $urandom_range(0, 32'h0080_0000);
                    foreach (fb_v[k]) fb_v[k] = $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
                end
                // gain near unity, small stable feedback
                1: begin
                    gain_v = $urandom_range(32'h0400_0000, 32'h0800_0000);
                    foreach (fb_v[k]) fb_v[k] = $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
                end
                // extremes of every register
                2: begin
                    gain_v = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
                    foreach (fb_v[k]) begin
                        case ($urandom_range(0, 3))
                            0: fb_v[k] = 32'h8000_0000;
                            1: fb_v[k] = 32'h7FFF_FFFF;
                            2: fb_v[k] = 32'hFFFF_FFFF;
                            default: fb_v[k] = 32'h0;
                        endcase
                    end
                end
                // anything goes
                default: begin
                    gain_v = $urandom;
                    foreach (fb_v[k]) fb_v[k] = $urandom;
                end
            endcase

            cfg_write(CFG_GAIN, gain_v);
            cfg_write(CFG_HIGHPASS, hp_v);
            cfg_write(CFG_FB_COEF1, fb_v[0]);
            cfg_write(CFG_FB_COEF2, fb_v[1]);
            cfg_write(CFG_FB_COEF3, fb_v[2]);
            cfg_write(CFG_FB_COEF4, fb_v[3]);
            if ($urandom_range(0, 1)) begin
                cfg_write($urandom_range(0, 1) ? CFG_SPARE6 : CFG_SPARE7, $urandom);
            end
            i_cfg_we <= 1'b0;

            // mix of full-range noise, extremes, small values, steps and sign flips
            for (int n = 0; n < SEG_ITEMS; n++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: smp = t_sample'($urandom);
                    5: smp = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                    6: smp = t_sample'($urandom_range(0, 128) - 64);
                    7: smp = '0;
                    8: smp = prev_smp;
                    default: smp = -prev_smp;
                endcase
                drive_sample(smp, 1'b0, '0);
                prev_smp = smp;
            end
        end

        wait_idle();
        if (mismatch_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/bwf_pkg.sv
rtl/bwf_tap.sv
rtl/butterworth_iir_filter.sv
tb/butterworth_iir_filter_tb.sv
